FILE: rtl/trwm_pkg.sv
// Package for the traffic rate window meter.
// Holds widths, register indexes, sequencer states and shared types.
// No dependencies; every other file imports it.
`default_nettype none

package trwm_pkg;

  // Field and state widths
  localparam int CNT_W      = 48;
  localparam int SECS_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int RATE_W     = CNT_W + FRAC_W;
  localparam int TOTAL_W    = 64;
  localparam int WIN_MAX    = 64;
  localparam int SLOT_W     = $clog2(WIN_MAX);
  localparam int LEN_W      = $clog2(WIN_MAX + 1);
  localparam int SUM_W      = RATE_W + SLOT_W;

  // Configuration port
  localparam int CFG_DATA_W = LEN_W;
  localparam int CFG_IDX_W  = 1;

  // Shared divider: radix-4 restoring, two quotient bits per cycle
  localparam int DIV_W      = SUM_W;
  localparam int DIVR_W     = SECS_W;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_ZERO_ON_RESET = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RX_RATE_GO,
    ST_RX_RATE_WAIT,
    ST_TX_RATE_GO,
    ST_TX_RATE_WAIT,
    ST_UPDATE,
    ST_RX_AVG_GO,
    ST_RX_AVG_WAIT,
    ST_TX_AVG_GO,
    ST_TX_AVG_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DSEL_RX_RATE,
    DSEL_TX_RATE,
    DSEL_RX_AVG,
    DSEL_TX_AVG
  } div_sel_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic     in_ready;
    logic     div_start;
    logic     div_wait;
    div_sel_e div_sel;
    logic     pre_upd;
    logic     win_upd;
    logic     out_load;
  } ctrl_t;

  // One window slot: both channel rates side by side
  typedef struct packed {
    logic [RATE_W-1:0] rx;
    logic [RATE_W-1:0] tx;
  } win_entry_t;

endpackage

`default_nettype wire

FILE: rtl/traffic_rate_window_meter.sv
// Channel  | Handshake              | Payload
// in       | in_valid_i/in_stall_o  | rx_count_i, tx_count_i, elapsed_seconds_i
// out      | out_valid_o/out_stall_i| rx/tx_average_o, rx/tx_peak_o, rx/tx_total_o
// cfg      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A measuring beat runs a slot read, four 62-bit divisions on the shared divider,
// a window update and the output load. A baseline beat skips to the output load.
// Reset at once clears the sequencer and architectural state, not the data registers;
// the window memory is cleared through valid bits.
// One beat is in work at a time; a finished result waits in the output register
// while the next beat is accepted, and a stalled output holds the sequencer at the end.
// Depends on trwm_pkg, trwm_ctrl, trwm_div and trwm_win_mem.
`default_nettype none

module traffic_rate_window_meter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [trwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [trwm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input beat
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [trwm_pkg::CNT_W-1:0]      rx_count_i,
  input  wire logic [trwm_pkg::CNT_W-1:0]      tx_count_i,
  input  wire logic [trwm_pkg::SECS_W-1:0]     elapsed_seconds_i,
  // result beat
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [trwm_pkg::RATE_W-1:0]          rx_average_o,
  output logic [trwm_pkg::RATE_W-1:0]          tx_average_o,
  output logic [trwm_pkg::RATE_W-1:0]          rx_peak_o,
  output logic [trwm_pkg::RATE_W-1:0]          tx_peak_o,
  output logic [trwm_pkg::TOTAL_W-1:0]         rx_total_o,
  output logic [trwm_pkg::TOTAL_W-1:0]         tx_total_o
);
  import trwm_pkg::*;

  ctrl_t               ctrl;
  logic                accept;
  logic                out_free;
  logic                win_clr;

  // Architectural state
  logic [CNT_W-1:0]    prev_rx_q, prev_tx_q;
  logic                primed_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SUM_W-1:0]    sum_rx_q, sum_tx_q;
  logic [RATE_W-1:0]   avg_rx_q, avg_tx_q;
  logic [RATE_W-1:0]   peak_rx_q, peak_tx_q;
  logic [TOTAL_W-1:0]  total_rx_q, total_tx_q;
  logic [LEN_W-1:0]    len_q;
  logic                zor_q;

  // Per-beat working registers
  logic [CNT_W-1:0]    diff_rx_q, diff_tx_q;
  logic                clr_rx_q, clr_tx_q;
  logic [SECS_W-1:0]   secs_q;
  logic [RATE_W-1:0]   rate_rx_q, rate_tx_q;

  // Output register
  logic                out_valid_q;
  logic [RATE_W-1:0]   out_avg_rx_q, out_avg_tx_q, out_peak_rx_q, out_peak_tx_q;
  logic [TOTAL_W-1:0]  out_total_rx_q, out_total_tx_q;

  // Combinational helpers
  logic                rx_dec, tx_dec;
  logic [SLOT_W-1:0]   slot_use;
  logic [LEN_W-1:0]    slot_nxt;
  logic [LEN_W-1:0]    len_wr;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIVR_W-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;
  logic [RATE_W-1:0]   quo_rate;
  win_entry_t          rd_entry;
  win_entry_t          wr_entry;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] base,
                                                 input logic [CNT_W-1:0]   diff);
    logic [TOTAL_W:0] s;
    s = {1'b0, base} + {{(TOTAL_W + 1 - CNT_W){1'b0}}, diff};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

  trwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .primed_i   (primed_q),
    .div_done_i (div_done),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign accept     = in_valid_i && ctrl.in_ready;
  assign in_stall_o = !ctrl.in_ready;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign win_clr    = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_WINDOW_LENGTH);

  // Beat front end: counter drops and slot wrap
  assign rx_dec   = rx_count_i < prev_rx_q;
  assign tx_dec   = tx_count_i < prev_tx_q;
  assign slot_use = ({1'b0, slot_q} >= len_q) ? '0 : slot_q;
  assign slot_nxt = {1'b0, slot_q} + LEN_W'(1);

  // Clamp written window length into 1..WIN_MAX
  always_comb begin
    len_wr = cfg_data_i[LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = LEN_W'(1);
    end else if (len_wr > LEN_W'(WIN_MAX)) begin
      len_wr = LEN_W'(WIN_MAX);
    end
  end

  // Divider operand select
  always_comb begin
    case (ctrl.div_sel)
      DSEL_RX_RATE: begin
        div_dividend = {{(DIV_W - RATE_W){1'b0}}, diff_rx_q, {FRAC_W{1'b0}}};
        div_divisor  = secs_q;
      end
      DSEL_TX_RATE: begin
        div_dividend = {{(DIV_W - RATE_W){1'b0}}, diff_tx_q, {FRAC_W{1'b0}}};
        div_divisor  = secs_q;
      end
      DSEL_RX_AVG: begin
        div_dividend = sum_rx_q;
        div_divisor  = {{(DIVR_W - LEN_W){1'b0}}, len_q};
      end
      DSEL_TX_AVG: begin
        div_dividend = sum_tx_q;
        div_divisor  = {{(DIVR_W - LEN_W){1'b0}}, len_q};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = {{(DIVR_W - 1){1'b0}}, 1'b1};
      end
    endcase
  end

  trwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_rate = div_quo[RATE_W-1:0];

  assign wr_entry.rx = rate_rx_q;
  assign wr_entry.tx = rate_tx_q;

  trwm_win_mem u_win_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (win_clr),
    .rd_en_i   (accept && primed_q),
    .rd_addr_i (slot_use),
    .wr_en_i   (ctrl.win_upd),
    .wr_addr_i (slot_q),
    .wr_data_i (wr_entry),
    .rd_data_o (rd_entry)
  );

  // Capture per-beat operands and rate division results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_rx_q <= rx_dec ? '0 : rx_count_i - prev_rx_q;
      diff_tx_q <= tx_dec ? '0 : tx_count_i - prev_tx_q;
      clr_rx_q  <= rx_dec && (zor_q || (avg_rx_q == '0));
      clr_tx_q  <= tx_dec && (zor_q || (avg_tx_q == '0));
      secs_q    <= (elapsed_seconds_i == '0) ? SECS_W'(1) : elapsed_seconds_i;
    end
    if (ctrl.div_wait && div_done && (ctrl.div_sel == DSEL_RX_RATE)) begin
      rate_rx_q <= quo_rate;
    end
    if (ctrl.div_wait && div_done && (ctrl.div_sel == DSEL_TX_RATE)) begin
      rate_tx_q <= quo_rate;
    end
  end

  // Architectural state update and configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rx_q  <= '0;
      prev_tx_q  <= '0;
      primed_q   <= 1'b0;
      slot_q     <= '0;
      sum_rx_q   <= '0;
      sum_tx_q   <= '0;
      avg_rx_q   <= '0;
      avg_tx_q   <= '0;
      peak_rx_q  <= '0;
      peak_tx_q  <= '0;
      total_rx_q <= '0;
      total_tx_q <= '0;
      len_q      <= LEN_W'(1);
      zor_q      <= 1'b0;
    end else begin
      // Take the beat: baseline readings and slot wrap
      if (accept) begin
        prev_rx_q <= rx_count_i;
        prev_tx_q <= tx_count_i;
        primed_q  <= 1'b1;
        if (primed_q) begin
          slot_q <= slot_use;
        end
      end
      // Drop the outgoing slot from the sums, apply clears, grow totals
      if (ctrl.pre_upd) begin
        sum_rx_q   <= sum_rx_q - {{(SUM_W - RATE_W){1'b0}}, rd_entry.rx};
        sum_tx_q   <= sum_tx_q - {{(SUM_W - RATE_W){1'b0}}, rd_entry.tx};
        total_rx_q <= sat_add(clr_rx_q ? '0 : total_rx_q, diff_rx_q);
        total_tx_q <= sat_add(clr_tx_q ? '0 : total_tx_q, diff_tx_q);
        if (clr_rx_q) begin
          peak_rx_q <= '0;
        end
        if (clr_tx_q) begin
          peak_tx_q <= '0;
        end
      end
      // Add the new rates and advance the slot
      if (ctrl.win_upd) begin
        sum_rx_q <= sum_rx_q + {{(SUM_W - RATE_W){1'b0}}, rate_rx_q};
        sum_tx_q <= sum_tx_q + {{(SUM_W - RATE_W){1'b0}}, rate_tx_q};
        slot_q   <= (slot_nxt >= len_q) ? '0 : slot_nxt[SLOT_W-1:0];
      end
      // Hold new averages and track peaks
      if (ctrl.div_wait && div_done && (ctrl.div_sel == DSEL_RX_AVG)) begin
        avg_rx_q <= quo_rate;
        if (quo_rate > peak_rx_q) begin
          peak_rx_q <= quo_rate;
        end
      end
      if (ctrl.div_wait && div_done && (ctrl.div_sel == DSEL_TX_AVG)) begin
        avg_tx_q <= quo_rate;
        if (quo_rate > peak_tx_q) begin
          peak_tx_q <= quo_rate;
        end
      end
      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WINDOW_LENGTH: begin
            len_q    <= len_wr;
            sum_rx_q <= '0;
            sum_tx_q <= '0;
            slot_q   <= '0;
          end
          REG_ZERO_ON_RESET: zor_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_avg_rx_q   <= avg_rx_q;
      out_avg_tx_q   <= avg_tx_q;
      out_peak_rx_q  <= peak_rx_q;
      out_peak_tx_q  <= peak_tx_q;
      out_total_rx_q <= total_rx_q;
      out_total_tx_q <= total_tx_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rx_average_o = out_avg_rx_q;
  assign tx_average_o = out_avg_tx_q;
  assign rx_peak_o    = out_peak_rx_q;
  assign tx_peak_o    = out_peak_tx_q;
  assign rx_total_o   = out_total_rx_q;
  assign tx_total_o   = out_total_tx_q;

endmodule

`default_nettype wire

FILE: rtl/trwm_div.sv
// Iterative unsigned divider shared by the rate and average divisions.
// Retires two quotient bits per cycle; done_o pulses once with quotient_o.
// Depends on trwm_pkg.
`default_nettype none

module trwm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [trwm_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [trwm_pkg::DIVR_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [trwm_pkg::DIV_W-1:0]        quotient_o
);
  import trwm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIVR_W-1:0]    dvs_q;
  logic [DIVR_W:0]      trial;

  // Two restoring steps: shift in a dividend bit, subtract when it fits
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DIVR_W-1:0];
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/trwm_win_mem.sv
// Rate window memory: one slot holds the receive and transmit rates.
// Registered synchronous read; per-slot valid bits give cleared reads.
// Depends on trwm_pkg.
`default_nettype none

module trwm_win_mem (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clr_i,
  input  wire logic                         rd_en_i,
  input  wire logic [trwm_pkg::SLOT_W-1:0]  rd_addr_i,
  input  wire logic                         wr_en_i,
  input  wire logic [trwm_pkg::SLOT_W-1:0]  wr_addr_i,
  input  wire trwm_pkg::win_entry_t         wr_data_i,
  output trwm_pkg::win_entry_t              rd_data_o
);
  import trwm_pkg::*;

  win_entry_t         mem_q [WIN_MAX];
  logic [WIN_MAX-1:0] valid_q;
  win_entry_t         rd_data_q;

  // Mark written slots; drop all marks on reset or window clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/trwm_ctrl.sv
// Item sequencer: read slot, four divisions on the shared divider with window
// update midway, output load (baseline: load only); drives one ctrl_t bundle.
// Depends on trwm_pkg.
`default_nettype none

module trwm_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       primed_i,
  input  wire logic       div_done_i,
  input  wire logic       out_free_i,
  output trwm_pkg::ctrl_t ctrl_o
);
  import trwm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = primed_i ? ST_READ : ST_DONE;
        end
      end
      ST_READ:         state_d = ST_RX_RATE_GO;
      ST_RX_RATE_GO:   state_d = ST_RX_RATE_WAIT;
      ST_RX_RATE_WAIT: if (div_done_i) state_d = ST_TX_RATE_GO;
      ST_TX_RATE_GO:   state_d = ST_TX_RATE_WAIT;
      ST_TX_RATE_WAIT: if (div_done_i) state_d = ST_UPDATE;
      ST_UPDATE:       state_d = ST_RX_AVG_GO;
      ST_RX_AVG_GO:    state_d = ST_RX_AVG_WAIT;
      ST_RX_AVG_WAIT:  if (div_done_i) state_d = ST_TX_AVG_GO;
      ST_TX_AVG_GO:    state_d = ST_TX_AVG_WAIT;
      ST_TX_AVG_WAIT:  if (div_done_i) state_d = ST_DONE;
      ST_DONE:         if (out_free_i) state_d = ST_IDLE;
      default:         state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.div_sel = DSEL_RX_RATE;
    case (state_q)
      ST_IDLE:         ctrl_o.in_ready = 1'b1;
      ST_READ:         ctrl_o.pre_upd  = 1'b1;
      ST_RX_RATE_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = DSEL_RX_RATE;
      end
      ST_RX_RATE_WAIT: begin
        ctrl_o.div_wait = 1'b1;
        ctrl_o.div_sel  = DSEL_RX_RATE;
      end
      ST_TX_RATE_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = DSEL_TX_RATE;
      end
      ST_TX_RATE_WAIT: begin
        ctrl_o.div_wait = 1'b1;
        ctrl_o.div_sel  = DSEL_TX_RATE;
      end
      ST_UPDATE:       ctrl_o.win_upd = 1'b1;
      ST_RX_AVG_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = DSEL_RX_AVG;
      end
      ST_RX_AVG_WAIT: begin
        ctrl_o.div_wait = 1'b1;
        ctrl_o.div_sel  = DSEL_RX_AVG;
      end
      ST_TX_AVG_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = DSEL_TX_AVG;
      end
      ST_TX_AVG_WAIT: begin
        ctrl_o.div_wait = 1'b1;
        ctrl_o.div_sel  = DSEL_TX_AVG;
      end
      ST_DONE:         ctrl_o.out_load = out_free_i;
      default:         ctrl_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/trwm_checker.sv
// Port-level checks for the traffic rate window meter, bound to the top level.
// Depends on trwm_pkg and traffic_rate_window_meter.
`default_nettype none

module trwm_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_o,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire logic [trwm_pkg::RATE_W-1:0]     rx_average_o,
  input  wire logic [trwm_pkg::RATE_W-1:0]     tx_average_o,
  input  wire logic [trwm_pkg::RATE_W-1:0]     rx_peak_o,
  input  wire logic [trwm_pkg::RATE_W-1:0]     tx_peak_o,
  input  wire logic [trwm_pkg::TOTAL_W-1:0]    rx_total_o,
  input  wire logic [trwm_pkg::TOTAL_W-1:0]    tx_total_o
);
  import trwm_pkg::*;

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its totals
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(rx_total_o) && $stable(tx_total_o)))
    else $error("result totals changed while stalled");

  // Only one beat in work: stall right after an accept
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // The peak never trails the average it tracks
  a_rx_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rx_peak_o >= rx_average_o))
    else $error("receive peak below receive average");

  a_tx_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tx_peak_o >= tx_average_o))
    else $error("transmit peak below transmit average");

endmodule

bind traffic_rate_window_meter trwm_checker u_trwm_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for traffic_rate_window_meter.
// Drives counter samples, predicts every result beat in-line and compares them.
// Depends on trwm_pkg and the traffic_rate_window_meter RTL.
`default_nettype none

module testbench;
  import trwm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int LONG_HOLD_AT   = 80;
  localparam int END_SETTLE     = 200;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_SAMPLES  = 73;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0]  rx;
    logic [CNT_W-1:0]  tx;
    logic [SECS_W-1:0] secs;
  } sample_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rx_avg;
    logic [RATE_W-1:0]  tx_avg;
    logic [RATE_W-1:0]  rx_peak;
    logic [RATE_W-1:0]  tx_peak;
    logic [TOTAL_W-1:0] rx_total;
    logic [TOTAL_W-1:0] tx_total;
  } meter_result_t;

  // DUT connections
  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  cfg_we_i          = 1'b0;
  cfg_reg_e              cfg_idx_i         = REG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_stall_o;
  logic [CNT_W-1:0]      rx_count_i        = '0;
  logic [CNT_W-1:0]      tx_count_i        = '0;
  logic [SECS_W-1:0]     elapsed_seconds_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i       = 1'b0;
  logic [RATE_W-1:0]     rx_average_o;
  logic [RATE_W-1:0]     tx_average_o;
  logic [RATE_W-1:0]     rx_peak_o;
  logic [RATE_W-1:0]     tx_peak_o;
  logic [TOTAL_W-1:0]    rx_total_o;
  logic [TOTAL_W-1:0]    tx_total_o;

  // Sample and result bookkeeping
  sample_t       pending_q[$];
  meter_result_t result_q[$];
  sample_t       held_sample;
  int            samples_queued   = 0;
  int            samples_accepted = 0;
  int            results_checked  = 0;
  int            fail_count       = 0;
  int            reg_writes       = 0;
  int            quiet_cycles     = 0;
  int            send_gap         = 0;
  int            recv_hold        = 0;
  logic          send_idle        = 1'b1;
  logic          recv_idle        = 1'b1;

  // Predicted meter state, index 0 is receive and 1 is transmit
  logic [CNT_W-1:0]   last_count [2];
  logic [RATE_W-1:0]  rate_ring  [2][WIN_MAX];
  logic [63:0]        ring_sum   [2];
  logic [RATE_W-1:0]  avg_now    [2];
  logic [RATE_W-1:0]  peak_now   [2];
  logic [TOTAL_W-1:0] total_now  [2];
  logic               baseline_taken;
  int                 ring_slot;
  int                 win_len;
  logic               clear_on_drop;

  traffic_rate_window_meter uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_count_i        (rx_count_i),
    .tx_count_i        (tx_count_i),
    .elapsed_seconds_i (elapsed_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .rx_average_o      (rx_average_o),
    .tx_average_o      (tx_average_o),
    .rx_peak_o         (rx_peak_o),
    .tx_peak_o         (tx_peak_o),
    .rx_total_o        (rx_total_o),
    .tx_total_o        (tx_total_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clear windows and sums, as a window length write does
  function automatic void clear_rings();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < WIN_MAX; i++) rate_ring[c][i] = '0;
      ring_sum[c] = '0;
    end
    ring_slot = 0;
  endfunction

  function automatic void reset_meter();
    for (int c = 0; c < 2; c++) begin
      last_count[c] = '0;
      avg_now[c]    = '0;
      peak_now[c]   = '0;
      total_now[c]  = '0;
    end
    clear_rings();
    baseline_taken = 1'b0;
    win_len        = 1;
    clear_on_drop  = 1'b0;
  endfunction

  // Advance one channel: difference, saturating total, rate, window average, peak
  function automatic void advance_channel(int c, logic [CNT_W-1:0] cur,
                                          logic [SECS_W-1:0] secs, int s);
    logic [63:0] diff;
    logic [63:0] divisor;
    logic [63:0] rate;
    diff    = '0;
    divisor = {48'd0, secs};
    if (cur < last_count[c]) begin
      if (clear_on_drop || avg_now[c] == '0) begin
        total_now[c] = '0;
        peak_now[c]  = '0;
      end
    end else begin
      diff = {16'd0, cur - last_count[c]};
    end
    if (total_now[c] > ~diff) total_now[c] = '1;
    else total_now[c] = total_now[c] + diff;
    rate            = (diff << FRAC_W) / divisor;
    ring_sum[c]     = ring_sum[c] - {8'd0, rate_ring[c][s]} + {8'd0, rate[RATE_W-1:0]};
    rate_ring[c][s] = rate[RATE_W-1:0];
    avg_now[c]      = RATE_W'(ring_sum[c] / 64'(win_len));
    if (avg_now[c] > peak_now[c]) peak_now[c] = avg_now[c];
    last_count[c] = cur;
  endfunction

  // Predict the result beat caused by one sample
  function automatic meter_result_t meter_step(sample_t smp);
    logic [SECS_W-1:0] secs;
    meter_result_t     res;
    secs = (smp.secs == '0) ? SECS_W'(1) : smp.secs;
    if (!baseline_taken) begin
      last_count[0]  = smp.rx;
      last_count[1]  = smp.tx;
      baseline_taken = 1'b1;
    end else begin
      if (ring_slot >= win_len) ring_slot = 0;
      advance_channel(0, smp.rx, secs, ring_slot);
      advance_channel(1, smp.tx, secs, ring_slot);
      ring_slot++;
      if (ring_slot >= win_len) ring_slot = 0;
    end
    res.rx_avg   = avg_now[0];
    res.tx_avg   = avg_now[1];
    res.rx_peak  = peak_now[0];
    res.tx_peak  = peak_now[1];
    res.rx_total = total_now[0];
    res.tx_total = total_now[1];
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] rand48();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[CNT_W-1:0];
  endfunction

  // Next counter reading: mostly climbing, sometimes a jump or a drop
  function automatic logic [CNT_W-1:0] next_count(logic [CNT_W-1:0] cur);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return cur + CNT_W'($urandom_range(0, 5000));
    if (pick < 72) return cur + CNT_W'($urandom());
    if (pick < 86) return cur + (rand48() >> $urandom_range(0, 47));
    if (pick < 93) return rand48();
    if (pick < 97) return cur - CNT_W'($urandom_range(1, 1000));
    return '0;
  endfunction

  function automatic logic [SECS_W-1:0] next_secs();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return SECS_W'($urandom_range(1, 3));
    if (pick < 72) return SECS_W'($urandom_range(0, 300));
    if (pick < 80) return '0;
    return SECS_W'($urandom_range(0, 65535));
  endfunction

  task automatic add_sample(logic [CNT_W-1:0] rx, logic [CNT_W-1:0] tx,
                            logic [SECS_W-1:0] secs);
    pending_q.push_back('{rx: rx, tx: tx, secs: secs});
    samples_queued++;
  endtask

  // Hold the sender until every queued sample has been answered
  task automatic drain();
    while (samples_accepted != samples_queued || result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    int len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (idx)
      REG_WINDOW_LENGTH: begin
        len = int'(value);
        if (len == 0) len = 1;
        if (len > WIN_MAX) len = WIN_MAX;
        win_len = len;
        clear_rings();
      end
      REG_ZERO_ON_RESET: begin
        clear_on_drop = value[0];
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Sender: offer queued samples, predict on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    logic fired;
    int   gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      fired = in_valid_i && !in_stall_o;
      gap   = send_gap;
      if (fired) begin
        result_q.push_back(meter_step(held_sample));
        samples_accepted++;
        gap = send_idle ? $urandom_range(0, 13) : 0;
      end
      // a stalled beat stays as it is
      if (!in_valid_i || fired) begin
        if (gap == 0 && pending_q.size() != 0) begin
          held_sample        = pending_q.pop_front();
          in_valid_i        <= 1'b1;
          rx_count_i        <= held_sample.rx;
          tx_count_i        <= held_sample.tx;
          elapsed_seconds_i <= held_sample.secs;
          send_gap          <= 0;
        end else begin
          in_valid_i <= 1'b0;
          send_gap   <= (gap > 0) ? gap - 1 : 0;
        end
      end
    end
  end

  // Receiver: compare each result beat, then stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    meter_result_t want;
    int            hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_hold   <= 0;
    end else begin
      hold = recv_hold;
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result beat arrived with no sample outstanding");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("rx_average", 64'(want.rx_avg), 64'(rx_average_o));
          check_field("tx_average", 64'(want.tx_avg), 64'(tx_average_o));
          check_field("rx_peak", 64'(want.rx_peak), 64'(rx_peak_o));
          check_field("tx_peak", 64'(want.tx_peak), 64'(tx_peak_o));
          check_field("rx_total", want.rx_total, rx_total_o);
          check_field("tx_total", want.tx_total, tx_total_o);
        end
        results_checked++;
        hold = recv_idle ? $urandom_range(0, 13) : 0;
        // one long back-pressure stretch so the input side fills and stalls
        if (results_checked == LONG_HOLD_AT) hold = LONG_HOLD;
      end else if (hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
      recv_hold   <= hold;
    end
  end

  // Count cycles in which no beat and no register write goes through
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $error("no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int               len_plan [RANDOM_PHASES];
    int               mode;
    logic [CNT_W-1:0] rx_now;
    logic [CNT_W-1:0] tx_now;
    len_plan = '{1, 64, 0, 127, 65, 2, -1, 7, 64, -1};
    reset_meter();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: baseline, zero and max seconds, full-range jumps and drops
    add_sample('0, COUNT_MAX, '0);
    add_sample(COUNT_MAX, COUNT_MAX, '0);
    add_sample(COUNT_MAX, '0, '1);
    add_sample(48'd1, 48'h8000_0000_0000, '1);
    add_sample(48'h1234, '0, 16'd1);
    add_sample(COUNT_MAX, COUNT_MAX, 16'd1);
    add_sample(COUNT_MAX, COUNT_MAX, 16'd3);
    add_sample(48'd5, 48'd7, 16'd2);
    drain();

    // Short window with clearing on drops; wrap the ring and drop with a live average
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
    write_register(REG_ZERO_ON_RESET, CFG_DATA_W'(1));
    add_sample(48'd1005, 48'd1007, 16'd2);
    add_sample(48'd3005, 48'd5007, 16'd4);
    add_sample(48'd8005, 48'd9007, 16'd1);
    add_sample(48'd8006, 48'd9008, '0);
    add_sample(48'd100, 48'd9500, 16'd2);
    add_sample(48'd200, 48'd9600, 16'd7);
    add_sample(COUNT_MAX, COUNT_MAX, '0);
    add_sample(COUNT_MAX, COUNT_MAX, '1);
    drain();

    // Random phases: new settings and idle pattern each time
    rx_now = COUNT_MAX;
    tx_now = COUNT_MAX;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_register(REG_WINDOW_LENGTH, (len_plan[p] < 0) ?
                     CFG_DATA_W'($urandom_range(1, WIN_MAX)) : CFG_DATA_W'(len_plan[p]));
      write_register(REG_ZERO_ON_RESET, CFG_DATA_W'(p % 2));
      mode      = p % 4;
      send_idle = (mode == 0 || mode == 1);
      recv_idle = (mode == 0 || mode == 2);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        rx_now = next_count(rx_now);
        tx_now = next_count(tx_now);
        add_sample(rx_now, tx_now, next_secs());
      end
      drain();
    end

    repeat (END_SETTLE) @(posedge clk_i);
    if (result_q.size() != 0) begin
      $error("%0d results never arrived", result_q.size());
      fail_count++;
    end
    $display("%0d samples sent, %0d results compared, %0d register writes",
             samples_accepted, results_checked, reg_writes);
    $display("windows of 1 to 64 slots, both drop modes, idle and back-to-back traffic");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
